FILE: rtl/core/diff_drive_odometry_integrator_unit_defines.svh
// assertion macros used by the checker file
`ifndef DIFF_DRIVE_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH

// concurrent check, masked while reset is asserted
`define DDOI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// concurrent check that also holds during reset
`define DDOI_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/ddoi_pkg.sv
`default_nettype none

package ddoi_pkg;

	// input item
	typedef struct packed {
		logic               operation;
		logic signed [23:0] lin_speed;
		logic signed [23:0] turn_rate;
	} in_item_t;

	// result item
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic        [31:0] heading;
		logic signed [23:0] applied_speed;
		logic signed [23:0] applied_rate;
	} out_item_t;

	// operation codes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_RESET = 1'b1;

	// default period, about 10 ms in q0.24 seconds
	localparam logic [23:0] TIME_STEP_RESET = 24'd167772;

	// cordic start vector length, q1.30
	localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;

	// binary angle units per radian, 2^32 / (2 pi)
	localparam logic signed [32:0] TURN_PER_RAD = 33'sd683565276;

	// atan(2^-i) as binary angle
	localparam logic [29:0] ATAN_TAB [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81,
		30'd41,        30'd20,        30'd10,        30'd5,
		30'd3,         30'd1,         30'd1,         30'd0
	};

endpackage

`default_nettype wire

FILE: rtl/core/diff_drive_odometry_integrator_unit.sv
`default_nettype none

// Dead-reckoning pose integrator for a differential-drive base. A tick item
// moves x and y by v*cos(heading)*dt and v*sin(heading)*dt at the heading from
// before the tick, then turns the heading by w*dt; a reset item zeroes the pose.
// Each item returns one result with the new pose and the applied rates. A tick
// runs the CORDIC rotation loop, one step per cycle, and uses the single 33x33
// multiplier five times; a reset item skips both. The block takes one item at
// a time; a finished result waits in the output register while the next item
// is accepted. time_step is written through cfg_wr_en / cfg_wr_data and must
// only change while the block is idle.
module diff_drive_odometry_integrator_unit #(
	parameter int CORDIC_STEPS = 24
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_wr_en,
	input  wire           [23:0] cfg_wr_data,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  ddoi_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  wire                  out_ready,
	output ddoi_pkg::out_item_t  out_item
);

	localparam int CNT_W = $clog2(CORDIC_STEPS);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_MUL_D = 10'b00_0000_0010,
		ST_MUL_R = 10'b00_0000_0100,
		ST_RND_R = 10'b00_0000_1000,
		ST_MUL_T = 10'b00_0001_0000,
		ST_STEP  = 10'b00_0010_0000,
		ST_ROT   = 10'b00_0100_0000,
		ST_MUL_X = 10'b00_1000_0000,
		ST_MUL_Y = 10'b01_0000_0000,
		ST_FIN   = 10'b10_0000_0000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (v < -35'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	state_t                   state_q;
	logic              [23:0] time_step_q;
	logic signed       [31:0] x_acc_q;
	logic signed       [31:0] y_acc_q;
	logic              [31:0] yaw_acc_q;
	logic                     rst_op_q;
	logic signed       [23:0] v_q;
	logic signed       [23:0] w_q;
	logic signed       [31:0] dist_q;
	logic signed       [31:0] rate_q;
	logic              [31:0] step_q;
	logic signed       [65:0] prod_q;
	logic signed       [33:0] cx_q;
	logic signed       [33:0] cy_q;
	logic signed       [33:0] cz_q;
	logic               [1:0] quad_q;
	logic         [CNT_W-1:0] cnt_q;
	logic                     out_valid_q;
	ddoi_pkg::out_item_t      out_item_q;

	logic signed       [32:0] mul_a;
	logic signed       [32:0] mul_b;
	logic signed       [33:0] cos_v;
	logic signed       [33:0] sin_v;
	logic signed       [33:0] xs;
	logic signed       [33:0] ys;
	logic signed       [33:0] atan_v;
	logic              [31:0] yaw_bias;
	logic              [31:0] yaw_diff;
	logic signed       [65:0] rnd16;
	logic signed       [65:0] rnd24;
	logic signed       [65:0] rnd38;
	logic signed       [34:0] pos_sum;
	logic                     slot_free;
	logic                     in_acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign slot_free = !out_valid_q || out_ready;

	// quadrant reduction of the current heading
	assign yaw_bias = yaw_acc_q + 32'h2000_0000;
	assign yaw_diff = yaw_acc_q - {yaw_bias[31:30], 30'd0};

	// rounding of the product register, half up
	assign rnd16   = (prod_q + 66'sd32768) >>> 16;
	assign rnd24   = (prod_q + 66'sd8388608) >>> 24;
	assign rnd38   = (prod_q + (66'sd1 <<< 37)) >>> 38;
	assign pos_sum = (state_q == ST_MUL_Y) ? 35'(x_acc_q) + $signed(rnd38[34:0])
	                                       : 35'(y_acc_q) + $signed(rnd38[34:0]);

	// cordic step operands
	assign xs     = cx_q >>> cnt_q;
	assign ys     = cy_q >>> cnt_q;
	assign atan_v = signed'({4'b0000, ddoi_pkg::ATAN_TAB[5'(cnt_q)]});

	// rotate the cordic result back by the quadrant
	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_v = cx_q;
				sin_v = cy_q;
			end
			2'd1: begin
				cos_v = -cy_q;
				sin_v = cx_q;
			end
			2'd2: begin
				cos_v = -cx_q;
				sin_v = -cy_q;
			end
			default: begin
				cos_v = cy_q;
				sin_v = -cx_q;
			end
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_D: begin
				mul_a = 33'(v_q);
				mul_b = signed'({9'd0, time_step_q});
			end
			ST_MUL_R: begin
				mul_a = 33'(w_q);
				mul_b = signed'({9'd0, time_step_q});
			end
			ST_MUL_T: begin
				mul_a = 33'(rate_q);
				mul_b = ddoi_pkg::TURN_PER_RAD;
			end
			ST_MUL_X: begin
				mul_a = 33'(dist_q);
				mul_b = 33'(cos_v);
			end
			ST_MUL_Y: begin
				mul_a = 33'(dist_q);
				mul_b = 33'(sin_v);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			time_step_q <= ddoi_pkg::TIME_STEP_RESET;
			x_acc_q     <= '0;
			y_acc_q     <= '0;
			yaw_acc_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				time_step_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (in_item.operation == ddoi_pkg::OP_RESET) ? ST_FIN
						                                                      : ST_MUL_D;
					end
				end
				ST_MUL_D: state_q <= ST_MUL_R;
				ST_MUL_R: state_q <= ST_RND_R;
				ST_RND_R: state_q <= ST_MUL_T;
				ST_MUL_T: state_q <= ST_STEP;
				ST_STEP:  state_q <= ST_ROT;
				ST_ROT: begin
					if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
						state_q <= ST_MUL_X;
					end
				end
				ST_MUL_X: state_q <= ST_MUL_Y;
				ST_MUL_Y: begin
					x_acc_q <= sat32(pos_sum);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (rst_op_q) begin
							x_acc_q   <= '0;
							y_acc_q   <= '0;
							yaw_acc_q <= '0;
						end else begin
							y_acc_q   <= sat32(pos_sum);
							yaw_acc_q <= yaw_acc_q + step_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rst_op_q <= (in_item.operation == ddoi_pkg::OP_RESET);
			v_q      <= in_item.lin_speed;
			w_q      <= in_item.turn_rate;
			cx_q     <= ddoi_pkg::CORDIC_KINV;
			cy_q     <= '0;
			cz_q     <= 34'(signed'(yaw_diff));
			quad_q   <= yaw_bias[31:30];
			cnt_q    <= '0;
		end
		if (state_q == ST_MUL_D || state_q == ST_MUL_R || state_q == ST_MUL_T ||
		    state_q == ST_MUL_X || state_q == ST_MUL_Y) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_MUL_R) begin
			dist_q <= rnd16[31:0];
		end
		if (state_q == ST_RND_R) begin
			rate_q <= rnd16[31:0];
		end
		if (state_q == ST_STEP) begin
			step_q <= rnd24[31:0];
		end
		// one cordic micro-rotation per cycle
		if (state_q == ST_ROT) begin
			if (!cz_q[33]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - atan_v;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + atan_v;
			end
			cnt_q <= cnt_q + 1'b1;
		end
		// result register
		if (state_q == ST_FIN && slot_free) begin
			if (rst_op_q) begin
				out_item_q <= '0;
			end else begin
				out_item_q.pos_x         <= x_acc_q;
				out_item_q.pos_y         <= sat32(pos_sum);
				out_item_q.heading       <= yaw_acc_q + step_q;
				out_item_q.applied_speed <= v_q;
				out_item_q.applied_rate  <= w_q;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ddoi_checker.sv
`default_nettype none

`include "diff_drive_odometry_integrator_unit_defines.svh"

module ddoi_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire                 out_valid,
	input wire                 out_ready,
	input ddoi_pkg::out_item_t out_item
);

	// a stalled result holds
	`DDOI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "result changed while stalled")

	// one item at a time: busy right after an accepted item
	`DDOI_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready stayed high after accept")

	// a new result only appears from a busy cycle
	`DDOI_ASSERT(a_result_from_busy, $rose(out_valid) |-> $past(!in_ready), "result appeared while idle")

	// reset leaves the block empty and ready
	`DDOI_ASSERT_RST(a_reset_state, !arst_n |-> !out_valid && in_ready, "bad state in reset")

endmodule

bind diff_drive_odometry_integrator_unit ddoi_checker u_ddoi_checker (.*);

`default_nettype wire
